// ===== src/keypad_code_alarm_controller_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Keypad alarm controller assertion macros
// Shorthand for the concurrent checks of the keypad alarm controller.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_CODE_ALARM_CONTROLLER_UNIT_ASSERT_SVH
`define KEYPAD_CODE_ALARM_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define KCAC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kcac: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define KCAC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kcac: next-cycle check failed");

`endif

// ===== src/kcac_pkg.sv =====
// ----------------------------------------------------------------------------
// Keypad alarm controller package
// Shared types, key codes, mode and event encodings.
// ----------------------------------------------------------------------------
package kcac_pkg;

    localparam int CODE_KEYS_DEF = 4;

    localparam logic [3:0]  KEY_A      = 4'd10;
    localparam logic [3:0]  KEY_STAR   = 4'd14;
    localparam logic [3:0]  KEY_HASH   = 4'd15;
    localparam logic [15:0] RESET_CODE = 16'h5938;

    // Encodings seen on the mode_now output.
    localparam logic [2:0] MODE_CODE_DISARMED = 3'd0;
    localparam logic [2:0] MODE_CODE_VERIFY   = 3'd1;
    localparam logic [2:0] MODE_CODE_NEWCODE  = 3'd2;
    localparam logic [2:0] MODE_CODE_ARMED    = 3'd3;
    localparam logic [2:0] MODE_CODE_ALARM    = 3'd4;

    typedef enum logic [4:0] {
        MODE_DISARMED = 5'b00001,
        MODE_VERIFY   = 5'b00010,
        MODE_NEWCODE  = 5'b00100,
        MODE_ARMED    = 5'b01000,
        MODE_ALARM    = 5'b10000
    } mode_t;

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_OLD_OK      = 3'd1,
        EV_WRONG       = 3'd2,
        EV_CHANGED     = 3'd3,
        EV_DISARM_CODE = 3'd4,
        EV_ARMED       = 3'd5,
        EV_TRIPPED     = 3'd6,
        EV_DISARM_STAR = 3'd7
    } event_t;

    typedef struct packed {
        logic       key_valid;
        logic [3:0] key_code;
        logic       motion;
    } poll_t;

    typedef struct packed {
        logic [2:0] mode_now;
        logic       alarm_on;
        logic [2:0] digits_entered;
        event_t     event_res;
    } result_t;

    function automatic logic [2:0] mode_code(input mode_t mode);
        logic [2:0] code;
        case (mode)
            MODE_VERIFY:  code = MODE_CODE_VERIFY;
            MODE_NEWCODE: code = MODE_CODE_NEWCODE;
            MODE_ARMED:   code = MODE_CODE_ARMED;
            MODE_ALARM:   code = MODE_CODE_ALARM;
            default:      code = MODE_CODE_DISARMED;
        endcase
        return code;
    endfunction

endpackage

// ===== src/kcac_in_stage.sv =====
// ----------------------------------------------------------------------------
// Keypad alarm controller input stage
// Registers one poll item and holds it until the mode logic takes it.
// ----------------------------------------------------------------------------
module kcac_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  kcac_pkg::poll_t poll_in,
    input  logic           step,
    output logic           poll_valid,
    output kcac_pkg::poll_t poll_out
);
    import kcac_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    poll_t poll_reg;
    logic  load;

    // The slot can take a new item when empty or when its item moves on now.
    assign load       = !valid_reg || step;
    assign in_stall   = !load;
    assign valid_next = load ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            poll_reg <= poll_in;
        end
    end

    assign poll_valid = valid_reg;
    assign poll_out   = poll_reg;

endmodule

// ===== src/kcac_mode_ctrl.sv =====
// ----------------------------------------------------------------------------
// Keypad alarm controller mode logic
// Holds mode, key entry and stored code; updates them once per item.
// ----------------------------------------------------------------------------
module kcac_mode_ctrl #(
    parameter int CODE_KEYS = kcac_pkg::CODE_KEYS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  kcac_pkg::poll_t   poll,
    output kcac_pkg::result_t result
);
    import kcac_pkg::*;

    localparam int CODE_W = 4 * CODE_KEYS;
    localparam int CNT_W  = (CODE_KEYS > 1) ? $clog2(CODE_KEYS) : 1;
    localparam logic [CODE_W-1:0] RESET_VAL = CODE_W'(RESET_CODE);

    mode_t             mode_reg,   mode_next;
    logic [CODE_W-1:0] keys_reg,   keys_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic [CODE_W-1:0] stored_reg, stored_next;
    event_t            ev;

    logic [CODE_W-1:0] keys_shift;
    logic [CNT_W:0]    count_inc;
    logic              entry_full;
    logic              code_match;

    // Keys shift in at the low end; the first key ends up in the top nibble.
    assign keys_shift = CODE_W'({keys_reg, poll.key_code});
    assign count_inc  = {1'b0, count_reg} + (CNT_W + 1)'(1);
    assign entry_full = count_inc >= (CNT_W + 1)'(CODE_KEYS);
    assign code_match = keys_shift == stored_reg;

    always_comb
    begin
        mode_next   = mode_reg;
        keys_next   = keys_reg;
        count_next  = count_reg;
        stored_next = stored_reg;
        ev          = EV_NONE;
        case (mode_reg)
            MODE_VERIFY:
            begin
                if (poll.key_valid)
                begin
                    keys_next  = keys_shift;
                    count_next = count_inc[CNT_W-1:0];
                    if (entry_full)
                    begin
                        mode_next  = code_match ? MODE_NEWCODE : MODE_DISARMED;
                        ev         = code_match ? EV_OLD_OK : EV_WRONG;
                        keys_next  = '0;
                        count_next = '0;
                    end
                end
            end
            MODE_NEWCODE:
            begin
                if (poll.key_valid)
                begin
                    keys_next  = keys_shift;
                    count_next = count_inc[CNT_W-1:0];
                    if (entry_full)
                    begin
                        stored_next = keys_shift;
                        mode_next   = MODE_DISARMED;
                        ev          = EV_CHANGED;
                        keys_next   = '0;
                        count_next  = '0;
                    end
                end
            end
            MODE_ARMED:
            begin
                // Motion takes priority over a star pressed in the same poll.
                if (poll.motion)
                begin
                    mode_next  = MODE_ALARM;
                    ev         = EV_TRIPPED;
                    keys_next  = '0;
                    count_next = '0;
                end
                else if (poll.key_valid && poll.key_code == KEY_STAR)
                begin
                    mode_next = MODE_DISARMED;
                    ev        = EV_DISARM_STAR;
                end
            end
            MODE_ALARM:
            begin
                if (poll.key_valid)
                begin
                    keys_next  = keys_shift;
                    count_next = count_inc[CNT_W-1:0];
                    if (entry_full)
                    begin
                        if (code_match)
                        begin
                            mode_next = MODE_DISARMED;
                        end
                        ev         = code_match ? EV_DISARM_CODE : EV_WRONG;
                        keys_next  = '0;
                        count_next = '0;
                    end
                end
            end
            default:
            begin
                mode_next = MODE_DISARMED;
                if (poll.key_valid && poll.key_code == KEY_A)
                begin
                    mode_next  = MODE_VERIFY;
                    keys_next  = '0;
                    count_next = '0;
                end
                else if (poll.key_valid && poll.key_code == KEY_HASH)
                begin
                    mode_next  = MODE_ARMED;
                    ev         = EV_ARMED;
                    keys_next  = '0;
                    count_next = '0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_DISARMED;
            keys_reg   <= '0;
            count_reg  <= '0;
            stored_reg <= RESET_VAL;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            keys_reg   <= keys_next;
            count_reg  <= count_next;
            stored_reg <= stored_next;
        end
    end

    assign result.mode_now       = mode_code(mode_next);
    assign result.alarm_on       = mode_next == MODE_ALARM;
    assign result.digits_entered = 3'(count_next);
    assign result.event_res      = ev;

endmodule

// ===== src/kcac_out_stage.sv =====
// ----------------------------------------------------------------------------
// Keypad alarm controller output stage
// Result register; decides when the mode logic may take the next item.
// ----------------------------------------------------------------------------
module kcac_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              poll_valid,
    output logic              step,
    input  kcac_pkg::result_t result_in,
    output logic              out_valid,
    input  logic              out_stall,
    output kcac_pkg::result_t result_out
);
    import kcac_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;
    logic    advance;

    // The result register is free when empty or when its item leaves now.
    assign advance    = !valid_reg || !out_stall;
    assign step       = poll_valid && advance;
    assign valid_next = advance ? poll_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;

endmodule

// ===== src/keypad_code_alarm_controller_unit.sv =====
// ----------------------------------------------------------------------------
// Keypad code alarm controller
// Each item is one keypad and motion sensor poll; each gives one result item
// with the mode after the poll, the alarm drive, keys entered and an event.
// A result is offered on the output from the result register once its item has
// passed the input register, and a new item can be accepted every cycle unless the
// input is stalled: the mode, entry and stored code update between the input register
// and the result register, with the full code compare done in parallel. The input
// stalls only while both registers hold items and the output is stalled. The stored
// code resets to 5 9 3 8.
// ----------------------------------------------------------------------------
`include "keypad_code_alarm_controller_unit_assert.svh"

module keypad_code_alarm_controller_unit #(
    parameter int CODE_KEYS = kcac_pkg::CODE_KEYS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       key_valid,
    input  logic [3:0] key_code,
    input  logic       motion,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] mode_now,
    output logic       alarm_on,
    output logic [2:0] digits_entered,
    output logic [2:0] event_res
);
    import kcac_pkg::*;

    poll_t   poll_in;
    poll_t   poll;
    logic    poll_valid;
    logic    step;
    result_t result_next;
    result_t result;

    assign poll_in.key_valid = key_valid;
    assign poll_in.key_code  = key_code;
    assign poll_in.motion    = motion;

    kcac_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .poll_in    (poll_in),
        .step       (step),
        .poll_valid (poll_valid),
        .poll_out   (poll)
    );

    kcac_mode_ctrl #(
        .CODE_KEYS (CODE_KEYS)
    ) u_mode_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .poll   (poll),
        .result (result_next)
    );

    kcac_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .poll_valid (poll_valid),
        .step       (step),
        .result_in  (result_next),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result_out (result)
    );

    assign mode_now       = result.mode_now;
    assign alarm_on       = result.alarm_on;
    assign digits_entered = result.digits_entered;
    assign event_res      = result.event_res;

    // The input side only stalls when both stages hold items and the output is stalled.
    `KCAC_ASSERT_IMP(a_stall_only_when_full, clk, rst_n, in_stall, out_valid && out_stall)
    `KCAC_ASSERT_IMP(a_alarm_matches_mode, clk, rst_n, out_valid,
        alarm_on == (mode_now == MODE_CODE_ALARM))
    `KCAC_ASSERT_IMP(a_entry_below_full, clk, rst_n, out_valid,
        32'(digits_entered) < 32'(CODE_KEYS))
    `KCAC_ASSERT_IMP(a_trip_enters_alarm, clk, rst_n, out_valid && event_res == EV_TRIPPED,
        mode_now == MODE_CODE_ALARM && digits_entered == 3'd0)
    `KCAC_ASSERT_NXT(a_accept_fills_stage, clk, rst_n, in_valid && !in_stall, !in_stall || out_valid)

endmodule

// ===== test/keypad_code_alarm_controller_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Keypad code alarm controller testbench
// Sends keypad and motion polls through the input channel and checks every
// status item against a mode tracker kept inside the bench. Directed tests
// cover the disarmed, code change, armed and alarm paths; a long random run
// follows sequences that mostly enter the right code, with random idling on
// both channels, a long output hold-off and pauses until the block drains.
// ----------------------------------------------------------------------------
module keypad_code_alarm_controller_unit_tb;

    import kcac_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          HOLD_CYCLES    = 120;
    localparam int          TAIL_CYCLES    = 10;
    localparam int          RANDOM_POLLS   = 1500;
    localparam logic [15:0] WRONG_CODE     = 16'h123F;
    localparam logic [15:0] DIRECTED_CODE  = 16'hFEA0;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       key_valid = 1'b0;
    logic [3:0] key_code = 4'd0;
    logic       motion = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] mode_now;
    logic       alarm_on;
    logic [2:0] digits_entered;
    logic [2:0] event_res;

    // Tracked state of the panel after every accepted poll.
    logic [2:0]  panel_mode = MODE_CODE_DISARMED;
    logic [15:0] entry_keys = 16'd0;
    logic [2:0]  entry_count = 3'd0;
    logic [15:0] stored_code = RESET_CODE;

    result_t status_due[$];
    int      mismatch_count = 0;
    int      burst_left = 0;
    int      idle_cycles = 0;
    logic    hold_output = 1'b0;

    keypad_code_alarm_controller_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .key_valid      (key_valid),
        .key_code       (key_code),
        .motion         (motion),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .mode_now       (mode_now),
        .alarm_on       (alarm_on),
        .digits_entered (digits_entered),
        .event_res      (event_res)
    );

    always #2 clk = ~clk;

    // Advances the tracked panel by one poll and queues the status it must report.
    task automatic apply_poll(input logic kv, input logic [3:0] kc, input logic mot);
        result_t due;
        event_t  ev;
        logic    full;
        logic    clear;
        ev = EV_NONE;
        full = 1'b0;
        clear = 1'b0;
        // Any key counts as a code key while an entry is open, even A, star and hash.
        if (kv && (panel_mode == MODE_CODE_VERIFY || panel_mode == MODE_CODE_NEWCODE
                || panel_mode == MODE_CODE_ALARM))
        begin
            entry_keys = {entry_keys[11:0], kc};
            entry_count = entry_count + 3'd1;
            full = (entry_count == CODE_KEYS_DEF);
        end
        case (panel_mode)
            MODE_CODE_VERIFY:
                if (full)
                begin
                    if (entry_keys == stored_code)
                    begin
                        panel_mode = MODE_CODE_NEWCODE;
                        ev = EV_OLD_OK;
                    end
                    else
                    begin
                        panel_mode = MODE_CODE_DISARMED;
                        ev = EV_WRONG;
                    end
                end
            MODE_CODE_NEWCODE:
                if (full)
                begin
                    stored_code = entry_keys;
                    panel_mode = MODE_CODE_DISARMED;
                    ev = EV_CHANGED;
                end
            MODE_CODE_ARMED:
                if (mot)
                begin
                    panel_mode = MODE_CODE_ALARM;
                    ev = EV_TRIPPED;
                    clear = 1'b1;
                end
                else if (kv && kc == KEY_STAR)
                begin
                    panel_mode = MODE_CODE_DISARMED;
                    ev = EV_DISARM_STAR;
                end
            MODE_CODE_ALARM:
                if (full)
                begin
                    if (entry_keys == stored_code)
                    begin
                        panel_mode = MODE_CODE_DISARMED;
                        ev = EV_DISARM_CODE;
                    end
                    else
                    begin
                        ev = EV_WRONG;
                    end
                end
            default:
            begin
                panel_mode = MODE_CODE_DISARMED;
                if (kv && kc == KEY_A)
                begin
                    panel_mode = MODE_CODE_VERIFY;
                    clear = 1'b1;
                end
                else if (kv && kc == KEY_HASH)
                begin
                    panel_mode = MODE_CODE_ARMED;
                    ev = EV_ARMED;
                    clear = 1'b1;
                end
            end
        endcase
        if (full || clear)
        begin
            entry_keys = 16'd0;
            entry_count = 3'd0;
        end
        due.mode_now = panel_mode;
        due.alarm_on = (panel_mode == MODE_CODE_ALARM);
        due.digits_entered = entry_count;
        due.event_res = ev;
        status_due.push_back(due);
    endtask

    // Offers one poll, in bursts separated by random gaps, and waits for its acceptance.
    task automatic send_poll(input logic kv, input logic [3:0] kc, input logic mot);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        key_valid <= kv;
        key_code <= kc;
        motion <= mot;
        do @(posedge clk); while (in_stall);
        apply_poll(kv, kc, mot);
    endtask

    task automatic enter_code(input logic [15:0] code);
        for (int i = 0; i < CODE_KEYS_DEF; i++)
        begin
            send_poll(1'b1, code[4 * (CODE_KEYS_DEF - 1 - i) +: 4], 1'b0);
        end
    endtask

    // Chooses a poll that mostly moves the panel forward from its present mode.
    function automatic poll_t pick_poll();
        poll_t p;
        int    roll;
        int    pos;
        roll = $urandom_range(0, 99);
        pos = CODE_KEYS_DEF - 1 - int'(entry_count);
        p.key_valid = 1'b1;
        p.key_code = 4'($urandom_range(0, 15));
        p.motion = ($urandom_range(0, 9) == 0);
        if (roll < 8)
        begin
            p.key_valid = 1'b0;
        end
        else
        begin
            case (panel_mode)
                MODE_CODE_DISARMED:
                    if (roll < 45)
                    begin
                        p.key_code = KEY_A;
                    end
                    else if (roll < 70)
                    begin
                        p.key_code = KEY_HASH;
                    end
                MODE_CODE_VERIFY, MODE_CODE_ALARM:
                    if (roll < 85)
                    begin
                        p.key_code = stored_code[4 * pos +: 4];
                    end
                MODE_CODE_ARMED:
                    if (roll < 35)
                    begin
                        p.motion = 1'b1;
                    end
                    else if (roll < 70)
                    begin
                        p.key_code = KEY_STAR;
                        p.motion = 1'b0;
                    end
                    else
                    begin
                        p.motion = 1'b0;
                    end
                default:
                begin
                    p.key_code = 4'($urandom_range(0, 15));
                end
            endcase
        end
        return p;
    endfunction

    task automatic send_random_polls(input int count);
        poll_t p;
        for (int i = 0; i < count; i++)
        begin
            p = pick_poll();
            send_poll(p.key_valid, p.key_code, p.motion);
        end
    endtask

    task automatic test_disarmed_polls();
        send_poll(1'b0, 4'd0, 1'b0);
        send_poll(1'b1, KEY_STAR, 1'b0);
        send_poll(1'b1, 4'd5, 1'b1);
        send_poll(1'b0, KEY_A, 1'b0);
    endtask

    task automatic test_code_change();
        // A wrong old code that ends on hash must fall back to disarmed, not arm.
        send_poll(1'b1, KEY_A, 1'b0);
        enter_code(WRONG_CODE);
        send_poll(1'b1, KEY_A, 1'b0);
        enter_code(RESET_CODE);
        enter_code(DIRECTED_CODE);
    endtask

    task automatic test_arm_and_alarm();
        send_poll(1'b1, KEY_HASH, 1'b0);
        send_poll(1'b1, 4'd3, 1'b0);
        // Motion wins over star while armed.
        send_poll(1'b1, KEY_STAR, 1'b1);
        enter_code(RESET_CODE);
        enter_code(DIRECTED_CODE);
        send_poll(1'b1, KEY_HASH, 1'b0);
        send_poll(1'b1, KEY_STAR, 1'b0);
    endtask

    task automatic test_random_polls();
        send_random_polls(RANDOM_POLLS);
    endtask

    task automatic test_output_hold();
        hold_output = 1'b1;
        send_random_polls(40);
    endtask

    task automatic test_drain_pause();
        for (int round = 0; round < 4; round++)
        begin
            send_random_polls(20);
            in_valid <= 1'b0;
            while (status_due.size() != 0) @(posedge clk);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_disarmed_polls();
        test_code_change();
        test_arm_and_alarm();
        test_random_polls();
        test_output_hold();
        test_drain_pause();
        in_valid <= 1'b0;
        while (status_due.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("keypad_code_alarm_controller_unit test passed");
        end
        else
        begin
            $display("keypad_code_alarm_controller_unit test failed");
        end
        $finish;
    end

    // Output side: stall segments of random length and density, plus a long
    // hold-off when a test asks for one.
    initial
    begin
        int seg_left;
        int stall_pct;
        seg_left = 0;
        stall_pct = 0;
        forever
        begin
            @(posedge clk);
            if (hold_output)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_output = 1'b0;
            end
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(8, 64);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            seg_left--;
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (status_due.size() == 0)
            begin
                $error("status item with none expected: mode_now %0d event_res %0d",
                    mode_now, event_res);
                mismatch_count++;
            end
            else
            begin
                want = status_due.pop_front();
                if (mode_now !== want.mode_now)
                begin
                    $error("mode_now: expected %0d, got %0d", want.mode_now, mode_now);
                    mismatch_count++;
                end
                if (alarm_on !== want.alarm_on)
                begin
                    $error("alarm_on: expected %0d, got %0d", want.alarm_on, alarm_on);
                    mismatch_count++;
                end
                if (digits_entered !== want.digits_entered)
                begin
                    $error("digits_entered: expected %0d, got %0d",
                        want.digits_entered, digits_entered);
                    mismatch_count++;
                end
                if (event_res !== want.event_res)
                begin
                    $error("event_res: expected %0d, got %0d", want.event_res, event_res);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("keypad_code_alarm_controller_unit test failed");
            $finish;
        end
    end

endmodule

// ===== keypad_code_alarm_controller_unit.f =====
+incdir+src
src/kcac_pkg.sv
src/kcac_in_stage.sv
src/kcac_mode_ctrl.sv
src/kcac_out_stage.sv
src/keypad_code_alarm_controller_unit.sv
test/keypad_code_alarm_controller_unit_tb.sv
